// ===== rtl/core/two_stack_queue_top_assert.svh =====
// Assertion macros used by the two-stack queue controller.
`ifndef TWO_STACK_QUEUE_TOP_ASSERT_SVH
`define TWO_STACK_QUEUE_TOP_ASSERT_SVH

// Property checked on every rising clock edge outside reset.
`define TSQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define TSQ_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/core/tsq_pkg.sv =====
// Types and constants of the two-stack queue.
`timescale 1ns / 1ps
`default_nettype none

package tsq_pkg;

	localparam int TSQ_DATA_W      = 32;
	localparam int TSQ_STACK_DEPTH = 128;

	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} tsq_op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_EMPTY    = 2'd2
	} tsq_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_XFER,
		S_DEQ_RD
	} tsq_state_t;

	typedef struct packed {
		tsq_op_t                       opcode;
		logic signed [TSQ_DATA_W-1:0]  value;
	} tsq_in_t;

	typedef struct packed {
		logic signed [TSQ_DATA_W-1:0]  data;
		tsq_status_t                   status;
	} tsq_out_t;

	// Port strobes of one stack memory.
	typedef struct packed {
		logic we;
		logic re;
	} tsq_mem_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/two_stack_queue_top.sv =====
// Two-stack FIFO queue: top level.
//
// Command channel: an item (opcode, value) is taken at a rising edge with
// start high and busy low. Every item yields exactly one result on rsp,
// shown for one cycle with valid high; the receiver cannot stall it.
// Enqueue writes the back stack in the accept cycle; its result (ok or
// overflow when the back stack is full) appears the next cycle and busy
// stays low, so enqueues run at one per cycle.
// Dequeue with words on the front stack reads the front memory; the word
// passes its registered read data and then the result register. With the
// front stack empty, the back stack of n words is first moved over, one
// word per cycle through the registered memory read, and then read as above.
// Every word moves at most once. Dequeue of an empty queue answers empty
// status and zero data in the cycle after accept.
// Reset clears both stack counts; the memories are not cleared.

`timescale 1ns / 1ps
`default_nettype none

module two_stack_queue_top
	import tsq_pkg::*;
#(
	parameter int STACK_DEPTH = TSQ_STACK_DEPTH
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	output logic         busy,
	input  wire tsq_in_t cmd,
	output logic         valid,
	output tsq_out_t     rsp
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	tsq_mem_ctl_t          back_ctl, front_ctl;
	logic [AW-1:0]         back_waddr, back_raddr, front_waddr, front_raddr;
	logic [TSQ_DATA_W-1:0] back_wdata, back_rdata, front_wdata, front_rdata;

	tsq_ctrl #(
		.DEPTH(STACK_DEPTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.valid       (valid),
		.rsp         (rsp),
		.back_ctl    (back_ctl),
		.back_waddr  (back_waddr),
		.back_wdata  (back_wdata),
		.back_raddr  (back_raddr),
		.back_rdata  (back_rdata),
		.front_ctl   (front_ctl),
		.front_waddr (front_waddr),
		.front_wdata (front_wdata),
		.front_raddr (front_raddr),
		.front_rdata (front_rdata)
	);

	tsq_stack_mem #(
		.DEPTH(STACK_DEPTH)
	) u_back_mem (
		.clk   (clk),
		.ctl   (back_ctl),
		.waddr (back_waddr),
		.wdata (back_wdata),
		.raddr (back_raddr),
		.rdata (back_rdata)
	);

	tsq_stack_mem #(
		.DEPTH(STACK_DEPTH)
	) u_front_mem (
		.clk   (clk),
		.ctl   (front_ctl),
		.waddr (front_waddr),
		.wdata (front_wdata),
		.raddr (front_raddr),
		.rdata (front_rdata)
	);

endmodule

`default_nettype wire

// ===== rtl/core/tsq_stack_mem.sv =====
// Stack storage: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tsq_stack_mem
	import tsq_pkg::*;
#(
	parameter int DEPTH = TSQ_STACK_DEPTH,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                  clk,
	input  wire tsq_mem_ctl_t          ctl,
	input  wire logic [AW-1:0]         waddr,
	input  wire logic [TSQ_DATA_W-1:0] wdata,
	input  wire logic [AW-1:0]         raddr,
	output logic      [TSQ_DATA_W-1:0] rdata
);

	logic [TSQ_DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/tsq_ctrl.sv =====
// Queue sequencer: stack counts, transfer loop and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "two_stack_queue_top_assert.svh"

module tsq_ctrl
	import tsq_pkg::*;
#(
	parameter int DEPTH = TSQ_STACK_DEPTH,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW   = $clog2(DEPTH + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire tsq_in_t               cmd,
	output logic                       valid,
	output tsq_out_t                   rsp,
	output tsq_mem_ctl_t               back_ctl,
	output logic [AW-1:0]              back_waddr,
	output logic [TSQ_DATA_W-1:0]      back_wdata,
	output logic [AW-1:0]              back_raddr,
	input  wire logic [TSQ_DATA_W-1:0] back_rdata,
	output tsq_mem_ctl_t               front_ctl,
	output logic [AW-1:0]              front_waddr,
	output logic [TSQ_DATA_W-1:0]      front_wdata,
	output logic [AW-1:0]              front_raddr,
	input  wire logic [TSQ_DATA_W-1:0] front_rdata
);

	tsq_state_t       state_q, state_d;
	logic [CW-1:0]    back_cnt_q, front_cnt_q;
	logic [CW-1:0]    back_dec, front_dec;
	logic             xfer_pend_s1;
	logic             valid_q;
	tsq_out_t         rsp_q;
	logic             accept, is_enq, back_full, back_empty, front_empty, xfer_done;

	assign accept      = start && (state_q == S_IDLE);
	assign is_enq      = (cmd.opcode == OP_ENQ);
	assign back_full   = (back_cnt_q == CW'(DEPTH));
	assign back_empty  = (back_cnt_q == '0);
	assign front_empty = (front_cnt_q == '0);
	assign back_dec    = back_cnt_q - CW'(1);
	assign front_dec   = front_cnt_q - CW'(1);
	assign xfer_done   = back_empty && !xfer_pend_s1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && !is_enq) begin
					if (!front_empty) begin
						state_d = S_DEQ_RD;
					end else if (!back_empty) begin
						state_d = S_XFER;
					end
				end
			end
			S_XFER: begin
				if (xfer_done) begin
					state_d = S_DEQ_RD;
				end
			end
			S_DEQ_RD: state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		back_ctl     = '0;
		front_ctl    = '0;
		back_waddr   = back_cnt_q[AW-1:0];
		back_wdata   = cmd.value;
		back_raddr   = back_dec[AW-1:0];
		front_waddr  = front_cnt_q[AW-1:0];
		front_wdata  = back_rdata;
		front_raddr  = front_dec[AW-1:0];
		case (state_q)
			S_IDLE: begin
				back_ctl.we  = accept && is_enq && !back_full;
				front_ctl.re = accept && !is_enq && !front_empty;
			end
			S_XFER: begin
				// pop back while the previous word lands on the front stack
				back_ctl.re  = !back_empty;
				front_ctl.we = xfer_pend_s1;
				front_ctl.re = xfer_done;
			end
			S_DEQ_RD: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			back_cnt_q   <= '0;
			front_cnt_q  <= '0;
			xfer_pend_s1 <= 1'b0;
			valid_q      <= 1'b0;
		end else begin
			state_q      <= state_d;
			xfer_pend_s1 <= back_ctl.re;
			valid_q      <= (accept && (is_enq || (front_empty && back_empty)))
			                || (state_q == S_DEQ_RD);
			if (back_ctl.we) begin
				back_cnt_q <= back_cnt_q + CW'(1);
			end else if (back_ctl.re) begin
				back_cnt_q <= back_dec;
			end
			if (front_ctl.we) begin
				front_cnt_q <= front_cnt_q + CW'(1);
			end else if (state_q == S_DEQ_RD) begin
				front_cnt_q <= front_dec;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DEQ_RD) begin
			rsp_q.data   <= front_rdata;
			rsp_q.status <= ST_OK;
		end else if (accept) begin
			rsp_q.data <= '0;
			if (is_enq) begin
				rsp_q.status <= back_full ? ST_OVERFLOW : ST_OK;
			end else begin
				rsp_q.status <= ST_EMPTY;
			end
		end
	end

	assign busy  = (state_q != S_IDLE);
	assign valid = valid_q;
	assign rsp   = rsp_q;

	`TSQ_NEVER(a_back_cnt_range, back_cnt_q > CW'(DEPTH), "back count beyond depth")
	`TSQ_NEVER(a_front_wr_range, front_ctl.we && (front_cnt_q >= CW'(DEPTH)), "front stack overrun")
	`TSQ_ASSERT(a_deq_not_empty, (state_q == S_DEQ_RD) |-> !front_empty, "pop of empty front stack")
	`TSQ_ASSERT(a_enq_result, (accept && is_enq) |=> valid_q, "enqueue without result")

endmodule

`default_nettype wire

// ===== test/tsq_fifo_ledger_pkg.sv =====
// Result ledger for the two-stack queue: tracks both stacks and checks each response.
`timescale 1ns / 1ps

package tsq_fifo_ledger_pkg;

	import tsq_pkg::*;

	class tsq_fifo_ledger;
		logic signed [TSQ_DATA_W-1:0] back_words [TSQ_STACK_DEPTH];
		logic signed [TSQ_DATA_W-1:0] front_words [TSQ_STACK_DEPTH];
		int unsigned back_cnt;
		int unsigned front_cnt;
		tsq_out_t awaited [$];
		int unsigned bad_cnt;

		function new();
			back_cnt = 0;
			front_cnt = 0;
			bad_cnt = 0;
		endfunction

		// Record the response this item must produce and update both stacks.
		function void note_cmd(tsq_in_t item);
			tsq_out_t want;
			want.data = '0;
			want.status = ST_OK;
			if (item.opcode == OP_ENQ) begin
				if (back_cnt >= TSQ_STACK_DEPTH) begin
					want.status = ST_OVERFLOW;
				end else begin
					back_words[back_cnt] = item.value;
					back_cnt++;
				end
			end else if (back_cnt == 0 && front_cnt == 0) begin
				want.status = ST_EMPTY;
			end else begin
				// Refill the front stack only when it has run dry; this reverses the order.
				if (front_cnt == 0) begin
					while (back_cnt > 0) begin
						back_cnt--;
						front_words[front_cnt] = back_words[back_cnt];
						front_cnt++;
					end
				end
				front_cnt--;
				want.data = front_words[front_cnt];
			end
			awaited.push_back(want);
		endfunction

		function void check_rsp(tsq_out_t got);
			tsq_out_t want;
			if (awaited.size() == 0) begin
				if (bad_cnt < 10)
					$display("%0t: unexpected rsp data=%h status=%0d", $realtime,
						got.data, got.status);
				bad_cnt++;
				return;
			end
			want = awaited.pop_front();
			if (got.data !== want.data || got.status !== want.status) begin
				if (bad_cnt < 10)
					$display("%0t: rsp error: data exp %h got %h, status exp %0d got %0d",
						$realtime, want.data, got.data, want.status, got.status);
				bad_cnt++;
			end
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction

		function bit failed();
			return bad_cnt != 0 || awaited.size() != 0;
		endfunction
	endclass

endpackage

// ===== test/two_stack_queue_top_tb.sv =====
// Testbench for the two-stack queue: directed and phased random traffic against a ledger.
`timescale 1ns / 1ps

module two_stack_queue_top_tb;

	import tsq_pkg::*;
	import tsq_fifo_ledger_pkg::*;

	typedef enum int {
		PH_FILL,
		PH_DRAIN,
		PH_MIXED
	} traffic_phase_t;

	localparam int ITEM_TARGET = 1550;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_WAIT  = 140;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	tsq_in_t  cmd;
	logic     valid;
	tsq_out_t rsp;

	tsq_fifo_ledger ledger;
	bit idle_on;
	int items_sent;
	int stall_cnt;

	two_stack_queue_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.valid  (valid),
		.rsp    (rsp)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (valid)
				ledger.check_rsp(rsp);
			if (start && !busy)
				ledger.note_cmd(cmd);
		end
	end

	// Abort when neither side moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || valid) begin
			stall_cnt <= 0;
		end else if (stall_cnt >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
	end

	function automatic logic [TSQ_DATA_W-1:0] pick_word();
		case ($urandom_range(0, 15))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send(tsq_op_t op, logic [TSQ_DATA_W-1:0] word);
		int gap;
		tsq_in_t item;
		gap = idle_on ? $urandom_range(0, 13) : 0;
		item.opcode = op;
		item.value = word;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		cmd <= item;
		do @(posedge clk); while (busy);
		items_sent++;
		@(negedge clk);
	endtask

	initial begin
		traffic_phase_t phase;
		int span;
		int enq_pct;
		tsq_op_t op;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		items_sent = 0;
		ledger = new();
		idle_on = 1'b1;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty dequeue, extreme words, a transfer, interleaved traffic, drain to empty.
		send(OP_DEQ, 32'hffff_ffff);
		send(OP_ENQ, 32'h7fff_ffff);
		send(OP_ENQ, 32'h8000_0000);
		send(OP_ENQ, 32'h0000_0000);
		send(OP_ENQ, 32'hffff_ffff);
		send(OP_ENQ, 32'h5555_5555);
		send(OP_DEQ, 32'h0000_0000);
		send(OP_ENQ, 32'haaaa_aaaa);
		idle_on = 1'b0;
		send(OP_DEQ, 32'h1234_5678);
		send(OP_DEQ, 32'h0000_0000);
		send(OP_DEQ, 32'h0000_0000);
		send(OP_DEQ, 32'h0000_0000);
		send(OP_DEQ, 32'h0000_0000);
		send(OP_DEQ, 32'h0000_0000);
		send(OP_ENQ, 32'h0000_0001);
		send(OP_ENQ, 32'hfedc_ba98);
		send(OP_DEQ, 32'h0000_0000);

		// Long fill phases reach overflow, also with room left on the front stack.
		while (items_sent < ITEM_TARGET) begin
			phase = traffic_phase_t'($urandom_range(0, 2));
			span = $urandom_range(20, 200);
			// Stop the last phase at the item target.
			if (span > ITEM_TARGET - items_sent)
				span = ITEM_TARGET - items_sent;
			idle_on = ($urandom_range(0, 3) != 0);
			case (phase)
				PH_FILL:  enq_pct = 95;
				PH_DRAIN: enq_pct = 10;
				default:  enq_pct = 50;
			endcase
			repeat (span) begin
				op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
				send(op, pick_word());
			end
		end

		start <= 1'b0;
		while (ledger.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (ledger.failed())
			$display("Mismatches found");
		else
			$display("No mismatches found");
		$finish;
	end

endmodule

// ===== two_stack_queue_top.f =====
+incdir+rtl/core
rtl/core/tsq_pkg.sv
rtl/core/tsq_stack_mem.sv
rtl/core/tsq_ctrl.sv
rtl/core/two_stack_queue_top.sv
test/tsq_fifo_ledger_pkg.sv
test/two_stack_queue_top_tb.sv
